// File: rtl/tpms_pkg.sv
// shared types and constants for the toggle pusher motor sequencer
package tpms_pkg;

   localparam int NumRegs = 8;
   localparam int RegIdxW = 3;

   // event kinds
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_SWITCH = 2'd1;
   localparam logic [1:0] FUNC_PARK   = 2'd2;

   // controller modes
   localparam logic [2:0] MODE_IDLE     = 3'd0;
   localparam logic [2:0] MODE_WAIT_FWD = 3'd1;
   localparam logic [2:0] MODE_FWD      = 3'd2;
   localparam logic [2:0] MODE_WAIT_BWD = 3'd3;
   localparam logic [2:0] MODE_BWD      = 3'd4;

   // register indexes
   localparam logic [RegIdxW-1:0] REG_FWD_CALM    = 3'd0;
   localparam logic [RegIdxW-1:0] REG_FWD_ANNOYED = 3'd1;
   localparam logic [RegIdxW-1:0] REG_FWD_FURIOUS = 3'd2;
   localparam logic [RegIdxW-1:0] REG_BWD_CALM    = 3'd3;
   localparam logic [RegIdxW-1:0] REG_BWD_ANNOYED = 3'd4;
   localparam logic [RegIdxW-1:0] REG_BWD_TEASING = 3'd5;
   localparam logic [RegIdxW-1:0] REG_BWD_FURIOUS = 3'd6;
   localparam logic [RegIdxW-1:0] REG_IDLE_TMO    = 3'd7;

   // irritation thresholds
   localparam logic [7:0] IRR_ANNOYED = 8'd3;
   localparam logic [7:0] IRR_ANGRY   = 8'd10;
   localparam logic [7:0] IRR_FURIOUS = 8'd20;
   localparam logic [7:0] IRR_MAX     = 8'd255;

   typedef logic [NumRegs-1:0][15:0] cfg_regs_type;

   localparam cfg_regs_type CFG_RESET = {16'd6000, 16'd1000, 16'd10, 16'd200,
                                         16'd10, 16'd1000, 16'd10, 16'd100};

   typedef struct packed {
      logic [1:0] func;
      logic       switch_on;
      logic       parked;
   } req_type;

   typedef struct packed {
      logic       drive_forward;
      logic       drive_backward;
      logic [2:0] mode;
      logic [7:0] irritation;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [7:0]  irritation;
      logic        delay_running;
      logic [15:0] delay_remaining;
      logic        idle_running;
      logic [15:0] idle_remaining;
   } state_type;

endpackage

// File: rtl/toggle_pusher_motor_sequencer.sv
// top level: register file, controller state and two-entry result buffer
// Each accepted word (a 10 ms tick, a switch change or a park change) yields exactly one
// result word with the mode, the drive bits and the irritation count after that event.
// The whole update is one registered step, so a word is taken every cycle while req_stall
// is low; a two-entry output buffer keeps input words flowing while one result is
// stalled, and req_stall rises only when both entries are full. The eight
// 16-bit registers sit at byte addresses 0, 4, ... 28 and read back through prdata.
module toggle_pusher_motor_sequencer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tpms_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output tpms_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [4:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import tpms_pkg::*;

   cfg_regs_type cfg_ff;
   state_type    state_ff;
   state_type    state_in;
   rsp_type      step_rsp;
   logic         out_valid_ff, out_valid_in;
   rsp_type      out_data_ff, out_data_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_type      skid_data_ff, skid_data_in;
   logic         accept;
   logic         out_take;
   logic [RegIdxW-1:0] reg_idx;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[4:2];
   assign csr_prdata = {16'd0, cfg_ff[reg_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         cfg_ff[reg_idx] <= csr_pwdata[15:0];
      end
   end

   tpms_step u_step (
      .cur (state_ff),
      .req (req_data),
      .cfg (cfg_ff),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   assign accept    = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (accept) begin
         if (!out_valid_in) begin
            out_valid_in = 1'b1;
            out_data_in  = step_rsp;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = step_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// File: rtl/tpms_step.sv
// next-state logic for one event: timers, irritation count and mode controller
module tpms_step (
   input  tpms_pkg::state_type    cur,
   input  tpms_pkg::req_type      req,
   input  tpms_pkg::cfg_regs_type cfg,
   output tpms_pkg::state_type    nxt,
   output tpms_pkg::rsp_type      rsp
);
   import tpms_pkg::*;

   logic        do_pass;
   logic        woke;
   logic [15:0] fwd_wait;
   logic [15:0] bwd_wait;

   always_comb begin
      nxt     = cur;
      do_pass = 1'b0;
      woke    = 1'b0;

      unique case (req.func)
         FUNC_TICK: begin
            // idle timer is served before the delay timer
            if (cur.idle_running) begin
               if (cur.idle_remaining <= 16'd1) begin
                  nxt.idle_running   = 1'b0;
                  nxt.idle_remaining = '0;
                  nxt.irritation     = '0;
               end else begin
                  nxt.idle_remaining = cur.idle_remaining - 16'd1;
               end
            end
            if (cur.delay_running) begin
               if (cur.delay_remaining <= 16'd1) begin
                  nxt.delay_running   = 1'b0;
                  nxt.delay_remaining = '0;
                  do_pass             = 1'b1;
                  woke                = 1'b1;
               end else begin
                  nxt.delay_remaining = cur.delay_remaining - 16'd1;
               end
            end
         end
         FUNC_SWITCH: begin
            if (req.switch_on && (cur.irritation != IRR_MAX)) begin
               nxt.irritation = cur.irritation + 8'd1;
            end
            do_pass = 1'b1;
         end
         FUNC_PARK: begin
            do_pass = 1'b1;
         end
         default: begin
         end
      endcase

      // wait lengths follow the count as it stands after this event
      if (nxt.irritation < IRR_ANNOYED) begin
         fwd_wait = cfg[REG_FWD_CALM];
         bwd_wait = cfg[REG_BWD_CALM];
      end else if (nxt.irritation < IRR_ANGRY) begin
         fwd_wait = cfg[REG_FWD_ANNOYED];
         bwd_wait = cfg[REG_BWD_ANNOYED];
      end else if (nxt.irritation < IRR_FURIOUS) begin
         fwd_wait = cfg[REG_FWD_FURIOUS];
         bwd_wait = cfg[REG_BWD_TEASING];
      end else begin
         fwd_wait = cfg[REG_FWD_FURIOUS];
         bwd_wait = cfg[REG_BWD_FURIOUS];
      end

      if (do_pass) begin
         nxt.idle_running   = 1'b1;
         nxt.idle_remaining = cfg[REG_IDLE_TMO];
         unique case (cur.mode)
            MODE_IDLE: begin
               if (req.switch_on) begin
                  if (!nxt.delay_running) begin
                     nxt.delay_running   = 1'b1;
                     nxt.delay_remaining = fwd_wait;
                  end
                  nxt.mode = MODE_WAIT_FWD;
               end
            end
            MODE_WAIT_FWD: begin
               if (!req.switch_on) begin
                  nxt.mode = MODE_IDLE;
               end else if (woke) begin
                  nxt.mode = MODE_FWD;
               end
            end
            MODE_FWD: begin
               if (!req.switch_on) begin
                  if (!nxt.delay_running) begin
                     nxt.delay_running   = 1'b1;
                     nxt.delay_remaining = bwd_wait;
                  end
                  nxt.mode = MODE_WAIT_BWD;
               end
            end
            MODE_WAIT_BWD: begin
               if (woke && req.switch_on) begin
                  nxt.mode = MODE_FWD;
               end else if (req.parked) begin
                  nxt.mode = MODE_IDLE;
               end else begin
                  nxt.mode = MODE_BWD;
               end
            end
            MODE_BWD: begin
               if (req.switch_on) begin
                  nxt.mode = MODE_FWD;
               end else if (req.parked) begin
                  nxt.mode = MODE_IDLE;
               end
            end
            default: begin
               nxt.mode = MODE_IDLE;
            end
         endcase
      end else if (cur.mode > MODE_BWD) begin
         nxt.mode = MODE_IDLE;
      end

      rsp.drive_forward  = (nxt.mode == MODE_FWD);
      rsp.drive_backward = (nxt.mode == MODE_BWD);
      rsp.mode           = nxt.mode;
      rsp.irritation     = nxt.irritation;
   end

endmodule

// File: rtl/tpms_checker.sv
// port-level checks for the toggle pusher motor sequencer and their binding
module tpms_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tpms_pkg::rsp_type rsp_data
);
   import tpms_pkg::*;

   // no result word may leave in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_mode_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.mode <= MODE_BWD))
      else $error("mode out of range");

   // drive bits follow the mode
   a_drive_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.drive_forward == (rsp_data.mode == MODE_FWD)) &&
                     (rsp_data.drive_backward == (rsp_data.mode == MODE_BWD))))
      else $error("drive bits disagree with mode");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result word changed");

endmodule

bind toggle_pusher_motor_sequencer tpms_checker u_tpms_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
